[rtl/fsubm_pkg.sv]
// Shared types and constants for the first substring match block.
// Used by fsubm_compare and first_substring_match_top; no dependencies.
package fsubm_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LO     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_MID_LO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_MID_HI = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HI     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LEN    = 3'd4;

  // Needle storage: four 64-bit registers hold 32 bytes, the rest read as zero
  localparam int NEEDLE_REG_BYTES = 32;
  localparam int NEEDLE_BYTE_IDX_W = $clog2(NEEDLE_REG_BYTES);
  localparam int NEEDLE_LEN_W     = 6;
  // Wide enough for any needle offset up to 64
  localparam int NEEDLE_OFS_W     = 7;

  typedef struct packed {
    logic [7:0] haystack_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_start;
    logic        position_overflow;
  } out_t;

endpackage

[rtl/fsubm_compare.sv]
// Masked window compare: checks the newest len bytes of the byte window
// against the needle. Depends on fsubm_pkg.
module fsubm_compare #(
  parameter int MAX_NEEDLE = 32,
  parameter int LEN_W      = 6
) (
  input  logic [8*MAX_NEEDLE-1:0]                    window,
  input  logic [8*fsubm_pkg::NEEDLE_REG_BYTES-1:0]   needle,
  input  logic [LEN_W-1:0]                           len,
  output logic                                       equal
);

  logic [MAX_NEEDLE-1:0] lane_ok;

  // Window entry j (newest at 0) pairs with needle byte len-1-j
  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_lane
    logic [fsubm_pkg::NEEDLE_OFS_W-1:0] ofs;
    logic [7:0]                         ref_byte;
    logic                               active;

    assign active = (fsubm_pkg::NEEDLE_OFS_W'(len) > fsubm_pkg::NEEDLE_OFS_W'(j));
    assign ofs    = fsubm_pkg::NEEDLE_OFS_W'(len) - fsubm_pkg::NEEDLE_OFS_W'(j)
                    - fsubm_pkg::NEEDLE_OFS_W'(1);

    always_comb begin
      if (ofs < fsubm_pkg::NEEDLE_OFS_W'(fsubm_pkg::NEEDLE_REG_BYTES)) begin
        ref_byte = needle[ofs[fsubm_pkg::NEEDLE_BYTE_IDX_W-1:0]*8 +: 8];
      end else begin
        ref_byte = 8'h00;
      end
    end

    assign lane_ok[j] = !active || (window[j*8 +: 8] == ref_byte);
  end

  assign equal = &lane_ok;

endmodule

[rtl/first_substring_match_top.sv]
// First substring match: streams haystack bytes, reports the first needle occurrence.
// Depends on fsubm_pkg and fsubm_compare.
//
//   channel  | signals                         | beat
//   ---------+---------------------------------+-----------------------------------
//   input    | in_valid, in_ready, in_data     | one haystack byte, final mark
//   output   | out_valid, out_ready, out_data  | found, match start, overflow flag
//   config   | cfg_we, cfg_index, cfg_data     | one register write, no handshake
//
// One byte is taken every cycle unless a final byte is held (see below). A byte is first
// registered in the input register, then the window compare and state update run on it;
// the result of a final byte is then registered for output. Reset (rst, synchronous) clears
// the needle, all per-haystack state but the byte window, and both valid flags. A final byte
// waits in the input register while the previous result is still unclaimed, stalling the input.
module first_substring_match_top #(
  parameter int MAX_NEEDLE    = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fsubm_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fsubm_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [fsubm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fsubm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Configuration registers
  logic [fsubm_pkg::CFG_DATA_W-1:0]   needle_lo, needle_mid_lo, needle_mid_hi, needle_hi;
  logic [fsubm_pkg::NEEDLE_LEN_W-1:0] needle_length;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  logic       s1_advance;

  // Per-haystack state
  logic [8*MAX_NEEDLE-1:0]  window;
  logic [8*MAX_NEEDLE-1:0]  window_next;
  logic [POSITION_BITS-1:0] byte_count;
  logic                     match_seen;
  logic [POSITION_BITS-1:0] first_start;
  logic                     count_saturated;

  logic [LEN_W-1:0]         len_sat;
  logic                     window_equal;
  logic                     indexable;
  logic [POSITION_BITS-1:0] count_inc;
  logic                     hit;
  logic                     match_seen_next;
  logic [POSITION_BITS-1:0] first_start_next;
  logic                     count_saturated_next;
  logic [POSITION_BITS+31:0] start_wide;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_lo     <= '0;
      needle_mid_lo <= '0;
      needle_mid_hi <= '0;
      needle_hi     <= '0;
      needle_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsubm_pkg::REG_NEEDLE_LO:     needle_lo     <= cfg_data;
        fsubm_pkg::REG_NEEDLE_MID_LO: needle_mid_lo <= cfg_data;
        fsubm_pkg::REG_NEEDLE_MID_HI: needle_mid_hi <= cfg_data;
        fsubm_pkg::REG_NEEDLE_HI:     needle_hi     <= cfg_data;
        fsubm_pkg::REG_NEEDLE_LEN:    needle_length <= cfg_data[fsubm_pkg::NEEDLE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the needle length to the window size
  always_comb begin
    if ({1'b0, needle_length} > fsubm_pkg::NEEDLE_OFS_W'(MAX_NEEDLE)) begin
      len_sat = LEN_W'(MAX_NEEDLE);
    end else begin
      len_sat = LEN_W'(needle_length);
    end
  end

  // Advance the input register unless a final byte meets an unclaimed result
  assign s1_advance = s1_valid && (!s1_final || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= in_data.haystack_byte;
      s1_final <= in_data.final_byte;
    end
  end

  // Shift the new byte into the window, newest at entry 0
  always_comb begin
    window_next[7:0] = s1_byte;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      window_next[k*8 +: 8] = window[(k-1)*8 +: 8];
    end
  end

  fsubm_compare #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .LEN_W      (LEN_W)
  ) u_compare (
    .window (window_next),
    .needle ({needle_hi, needle_mid_hi, needle_mid_lo, needle_lo}),
    .len    (len_sat),
    .equal  (window_equal)
  );

  // Record the first match; a byte past the counter range cannot complete one
  assign indexable = (byte_count != POS_MAX);
  assign count_inc = byte_count + POSITION_BITS'(1);
  assign hit = indexable && !match_seen && (len_sat != '0)
               && (count_inc >= POSITION_BITS'(len_sat)) && window_equal;

  assign match_seen_next      = match_seen || hit;
  assign first_start_next     = hit ? (count_inc - POSITION_BITS'(len_sat)) : first_start;
  assign count_saturated_next = count_saturated || !indexable;
  assign start_wide           = {32'b0, first_start_next};

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      window <= window_next;
    end
  end

  // Update per-haystack state; drop it after a final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      match_seen      <= 1'b0;
      first_start     <= '0;
      count_saturated <= 1'b0;
    end else if (s1_advance) begin
      if (s1_final) begin
        byte_count      <= '0;
        match_seen      <= 1'b0;
        first_start     <= '0;
        count_saturated <= 1'b0;
      end else begin
        byte_count      <= indexable ? count_inc : byte_count;
        match_seen      <= match_seen_next;
        first_start     <= first_start_next;
        count_saturated <= count_saturated_next;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_final) begin
      out_data.found             <= match_seen_next;
      out_data.match_start       <= match_seen_next ? start_wide[31:0] : 32'd0;
      out_data.position_overflow <= count_saturated_next;
    end
  end

  // A missing match always reports start zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_start == 32'd0)
    else $error("result without match carries nonzero start");

  // A final byte leaves the haystack state cleared
  assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_final |=> byte_count == '0 && !match_seen && !count_saturated)
    else $error("haystack state not cleared after final byte");

  // The overflow flag is only set once the counter is full
  assert property (@(posedge clk) disable iff (rst)
    count_saturated |-> byte_count == POS_MAX)
    else $error("overflow flagged with counter below its limit");

  // A held final byte means the result register is occupied and unclaimed
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |-> out_valid && !out_ready)
    else $error("input register stalled without output backpressure");

  // A recorded match start never lies past the bytes seen so far
  assert property (@(posedge clk) disable iff (rst)
    match_seen |-> first_start < byte_count)
    else $error("match start beyond received bytes");

endmodule
